@@ sv/tpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants shared by the pose conditioner modules.
// ----------------------------------------------------------------------------
package tpc_pkg;

    typedef struct packed {
        logic [3:0]         tracker_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [16:0]        confidence;
        logic [15:0]        gap_ms;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               tracking_ok;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_ENABLE_MASK = 3'd0,
        CFG_OK_CONF     = 3'd1,
        CFG_HIP_MIN     = 3'd2,
        CFG_HIP_MAX     = 3'd3,
        CFG_FOOT_MIN    = 3'd4,
        CFG_FOOT_MAX    = 3'd5,
        CFG_MAX_SPEED   = 3'd6,
        CFG_MAX_GAP     = 3'd7
    } t_cfg_idx;

    localparam logic [9:0]  RST_ENABLE_MASK = 10'd0;
    localparam logic [16:0] RST_OK_CONF     = 17'd39322;
    localparam logic [31:0] RST_HIP_MIN     = 32'd52429;
    localparam logic [31:0] RST_HIP_MAX     = 32'd78643;
    localparam logic [31:0] RST_FOOT_MIN    = 32'd0;
    localparam logic [31:0] RST_FOOT_MAX    = 32'd19661;
    localparam logic [30:0] RST_MAX_SPEED   = 31'd327680;
    localparam logic [15:0] RST_MAX_GAP     = 16'd100;

    localparam int MASK_BITS = 10;
    localparam logic [16:0] CONF_ONE = 17'd65536;

    // blend: 0.975 new + 0.025 prev = (39 new + prev) / 40, round half up
    localparam logic signed [39:0] BLEND_NEW   = 40'sd39;
    localparam logic signed [39:0] BLEND_ROUND = 40'sd20;
    localparam logic [39:0]        BLEND_BIAS  = 40'd39;
    // /40 is >>3 then /5, the /5 done on two halves by reciprocal multiply
    localparam logic [16:0]        BLEND_DIV5  = 17'd5;
    localparam logic [17:0]        DIV5_HI_MUL = 18'd209716;   // ceil(2^20 / 5)
    localparam logic [21:0]        DIV5_LO_MUL = 22'd3355444;  // ceil(2^24 / 5)

    localparam logic [42:0] VEL_SCALE = 43'd1000;
    localparam int          QUAT_SHIFT = 28;
    localparam logic [63:0] ROT_ONE = 64'd16384;

    // prev_raw x/y/z then prev_out x/y/z
    localparam int MEM_W = 192;

endpackage

@@ sv/tracker_pose_conditioner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pose_conditioner
// Per-tracker pose smoothing, height clamp, quaternion normalisation and
// speed-limited velocity.
// ----------------------------------------------------------------------------
// One report is worked on at a time. The blend divides by 40 are done by
// reciprocal multiplication. An accepted report runs through one shared
// divider (up to four quaternion divides, three velocity divides and three
// speed rescales) and one shared square root unit. Per-tracker history sits
// in one RAM read once and written once per accepted report, with a history
// valid bit per tracker held in flops. The next report is taken while the
// previous result still waits in the output register.
module tracker_pose_conditioner
    import tpc_pkg::*;
#(
    parameter int TRACKERS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;

    typedef enum logic [23:0] {
        S_IDLE    = 24'd1,
        S_READ    = 24'd1 << 1,
        S_BLEND   = 24'd1 << 2,
        S_BLEND_W = 24'd1 << 3,
        S_CLAMP   = 24'd1 << 4,
        S_QSUM    = 24'd1 << 5,
        S_QSQRT   = 24'd1 << 6,
        S_QSQRT_W = 24'd1 << 7,
        S_QDIV    = 24'd1 << 8,
        S_QDIV_W  = 24'd1 << 9,
        S_VCHK    = 24'd1 << 10,
        S_VDIV    = 24'd1 << 11,
        S_VDIV_W  = 24'd1 << 12,
        S_VSHIFT  = 24'd1 << 13,
        S_VSQ     = 24'd1 << 14,
        S_VACC    = 24'd1 << 15,
        S_VSQRT   = 24'd1 << 16,
        S_VSQRT_W = 24'd1 << 17,
        S_VCMP    = 24'd1 << 18,
        S_VMUL    = 24'd1 << 19,
        S_VSDIV   = 24'd1 << 20,
        S_VSDIV_W = 24'd1 << 21,
        S_FIN     = 24'd1 << 22,
        S_OUT     = 24'd1 << 23
    } t_state;

    // configuration
    logic [9:0]         r_enable_mask;
    logic [16:0]        r_ok_conf;
    logic signed [31:0] r_hip_min, r_hip_max, r_foot_min, r_foot_max;
    logic [30:0]        r_max_speed;
    logic [15:0]        r_max_gap;

    t_state             r_state;
    t_in_item           r_item;
    logic               r_ok;
    logic               r_hp;
    logic [TRACKERS-1:0] r_hasprev;
    logic signed [31:0] r_prev_raw [3];
    logic signed [31:0] r_prev_out [3];
    logic signed [31:0] r_o [3];
    logic signed [15:0] r_rot [4];
    logic signed [43:0] r_v [3];
    logic [1:0]         r_k;
    logic [14:0]        r_bq_hi;
    logic [2:0]         r_brem;
    logic [32:0]        r_qacc;
    logic [31:0]        r_root;
    logic [42:0]        r_av;
    logic [3:0]         r_sh;
    logic [61:0]        r_prod;
    logic [63:0]        r_vacc;
    logic [31:0]        r_m;
    t_out_item          r_out;
    logic               r_out_valid;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= RST_ENABLE_MASK;
            r_ok_conf     <= RST_OK_CONF;
            r_hip_min     <= RST_HIP_MIN;
            r_hip_max     <= RST_HIP_MAX;
            r_foot_min    <= RST_FOOT_MIN;
            r_foot_max    <= RST_FOOT_MAX;
            r_max_speed   <= RST_MAX_SPEED;
            r_max_gap     <= RST_MAX_GAP;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE_MASK: r_enable_mask <= i_cfg_data[9:0];
                CFG_OK_CONF:     r_ok_conf     <= i_cfg_data[16:0];
                CFG_HIP_MIN:     r_hip_min     <= i_cfg_data;
                CFG_HIP_MAX:     r_hip_max     <= i_cfg_data;
                CFG_FOOT_MIN:    r_foot_min    <= i_cfg_data;
                CFG_FOOT_MAX:    r_foot_max    <= i_cfg_data;
                CFG_MAX_SPEED:   r_max_speed   <= i_cfg_data[30:0];
                CFG_MAX_GAP:     r_max_gap     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- memory
    logic              mem_we;
    logic [MEM_W-1:0]  mem_wdata;
    logic [MEM_W-1:0]  mem_rdata;
    logic [AW-1:0]     id_a;

    assign id_a      = r_item.tracker_id[AW-1:0];
    assign mem_we    = (r_state == S_FIN);
    assign mem_wdata = {r_o[2], r_o[1], r_o[0],
                        r_item.pos_z, r_item.pos_y, r_item.pos_x};

    tpc_ram #(.WIDTH(MEM_W), .DEPTH(TRACKERS), .AW(AW)) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (id_a),
        .i_wdata (mem_wdata),
        .i_raddr (i_in_data.tracker_id[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------- datapath
    logic in_acc;
    logic valid_rep;
    logic [15:0] mask_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign mask_ext   = {6'd0, r_enable_mask};
    assign valid_rep  = ({1'b0, i_in_data.tracker_id} < 5'(TRACKERS))
                        && (i_in_data.confidence <= CONF_ONE)
                        && mask_ext[i_in_data.tracker_id];

    // blend
    logic signed [31:0] raw_k;
    logic signed [39:0] blend_a;
    logic [39:0]        blend_mag;
    logic [34:0]        bhi_prod;
    logic [14:0]        bhi_q;
    logic [16:0]        bhi_rem;
    logic [20:0]        blo_num;
    logic [42:0]        blo_prod;
    logic [32:0]        blend_q;

    always_comb begin
        case (r_k)
            2'd0:    raw_k = r_item.pos_x;
            2'd1:    raw_k = r_item.pos_y;
            default: raw_k = r_item.pos_z;
        endcase
    end

    assign blend_a   = 40'(raw_k) * BLEND_NEW + 40'(r_prev_raw[r_k]) + BLEND_ROUND;
    // floor division: negative numerators round away from zero
    assign blend_mag = blend_a[39] ? 40'(-blend_a) + BLEND_BIAS : 40'(blend_a);

    // magnitude stays below 2^38; upper half of mag/8 first, then the rest
    assign bhi_prod = 35'(blend_mag[37:21]) * 35'(DIV5_HI_MUL);
    assign bhi_q    = bhi_prod[34:20];
    assign bhi_rem  = blend_mag[37:21] - 17'(bhi_q) * BLEND_DIV5;
    assign blo_num  = {r_brem, blend_mag[20:3]};
    assign blo_prod = 43'(blo_num) * 43'(DIV5_LO_MUL);
    assign blend_q  = {r_bq_hi, blo_prod[41:24]};

    // quaternion
    logic signed [15:0] q_k;
    logic [15:0]        q_abs;
    logic [63:0]        q_num;
    logic [15:0]        rot_mag;

    always_comb begin
        case (r_k)
            2'd0:    q_k = r_item.quat_w;
            2'd1:    q_k = r_item.quat_x;
            2'd2:    q_k = r_item.quat_y;
            default: q_k = r_item.quat_z;
        endcase
    end

    assign q_abs = q_k[15] ? 16'(-q_k) : 16'(q_k);
    assign q_num = ({48'd0, q_abs} << QUAT_SHIFT) + {33'd0, r_root[31:1]};

    // velocity
    logic signed [32:0] d_k;
    logic [32:0]        d_abs;
    logic [42:0]        v_num;
    logic [42:0]        v_abs;
    logic [42:0]        v_shifted;
    logic [30:0]        u_k;
    logic [63:0]        m_shifted;

    assign d_k       = 33'(r_o[r_k]) - 33'(r_prev_out[r_k]);
    assign d_abs     = d_k[32] ? 33'(-d_k) : 33'(d_k);
    assign v_num     = 43'(d_abs) * VEL_SCALE;
    assign v_abs     = r_v[r_k][43] ? 43'(-r_v[r_k]) : r_v[r_k][42:0];
    assign v_shifted = v_abs >> r_sh;
    assign u_k       = v_shifted[30:0];
    assign m_shifted = {32'd0, r_m} << r_sh;

    // shared units
    logic        div_start, div_done;
    logic [63:0] div_num, div_quot;
    logic [31:0] div_den;
    logic        sqrt_start, sqrt_done;
    logic [63:0] sqrt_rad;
    logic [31:0] sqrt_root;

    always_comb begin
        div_start = 1'b1;
        div_num   = {2'd0, r_prod};
        div_den   = r_m;
        case (r_state)
            S_QDIV: begin
                div_num = q_num;
                div_den = r_root;
            end
            S_VDIV: begin
                div_num = {21'd0, v_num};
                div_den = {16'd0, r_item.gap_ms};
            end
            S_VSDIV: ;
            default: div_start = 1'b0;
        endcase
    end

    assign sqrt_start = (r_state == S_QSQRT && r_qacc != '0) || (r_state == S_VSQRT);
    assign sqrt_rad   = (r_state == S_VSQRT) ? r_vacc : ({31'd0, r_qacc} << QUAT_SHIFT);

    tpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tpc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign rot_mag = (div_quot > ROT_ONE) ? ROT_ONE[15:0] : div_quot[15:0];

    // result assembly
    t_out_item out_next;
    logic      out_load;

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        out_next = '0;
        if (r_ok) begin
            out_next.accepted    = 1'b1;
            out_next.out_x       = r_o[0];
            out_next.out_y       = r_o[1];
            out_next.out_z       = r_o[2];
            out_next.rot_w       = r_rot[0];
            out_next.rot_x       = r_rot[1];
            out_next.rot_y       = r_rot[2];
            out_next.rot_z       = r_rot[3];
            out_next.vel_x       = r_v[0][31:0];
            out_next.vel_y       = r_v[1][31:0];
            out_next.vel_z       = r_v[2][31:0];
            out_next.tracking_ok = r_item.confidence > r_ok_conf;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hasprev   <= '0;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_in_data;
                        r_ok   <= valid_rep;
                        r_k    <= '0;
                        r_qacc <= '0;
                        for (int i = 0; i < 4; i++) begin
                            r_rot[i] <= '0;
                        end
                        for (int i = 0; i < 3; i++) begin
                            r_v[i] <= '0;
                        end
                        r_state <= valid_rep ? S_READ : S_OUT;
                    end
                end
                S_READ: begin
                    r_prev_raw[0] <= mem_rdata[31:0];
                    r_prev_raw[1] <= mem_rdata[63:32];
                    r_prev_raw[2] <= mem_rdata[95:64];
                    r_prev_out[0] <= mem_rdata[127:96];
                    r_prev_out[1] <= mem_rdata[159:128];
                    r_prev_out[2] <= mem_rdata[191:160];
                    r_hp          <= r_hasprev[id_a];
                    r_o[0]        <= r_item.pos_x;
                    r_o[1]        <= r_item.pos_y;
                    r_o[2]        <= r_item.pos_z;
                    r_state       <= r_hasprev[id_a] ? S_BLEND : S_CLAMP;
                end
                S_BLEND: begin
                    r_bq_hi <= bhi_q;
                    r_brem  <= bhi_rem[2:0];
                    r_state <= S_BLEND_W;
                end
                S_BLEND_W: begin
                    r_o[r_k] <= blend_a[39] ? 32'(-blend_q) : blend_q[31:0];
                    r_k      <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    r_state  <= (r_k == 2'd2) ? S_CLAMP : S_BLEND;
                end
                S_CLAMP: begin
                    // low bound first, so the high bound wins when they cross
                    if (r_item.tracker_id == 4'd0) begin
                        if (r_o[1] > r_hip_max || r_hip_min > r_hip_max) begin
                            if (r_o[1] > r_hip_max || r_o[1] < r_hip_min) begin
                                r_o[1] <= r_hip_max;
                            end
                        end else if (r_o[1] < r_hip_min) begin
                            r_o[1] <= r_hip_min;
                        end
                    end else if (r_item.tracker_id == 4'd1 || r_item.tracker_id == 4'd2) begin
                        if (r_o[1] > r_foot_max || r_foot_min > r_foot_max) begin
                            if (r_o[1] > r_foot_max || r_o[1] < r_foot_min) begin
                                r_o[1] <= r_foot_max;
                            end
                        end else if (r_o[1] < r_foot_min) begin
                            r_o[1] <= r_foot_min;
                        end
                    end
                    r_k     <= '0;
                    r_state <= S_QSUM;
                end
                S_QSUM: begin
                    r_qacc  <= r_qacc + 33'(32'(q_k * q_k));
                    r_k     <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_QSQRT;
                    end
                end
                S_QSQRT: begin
                    // zero quaternion passes as zero
                    r_state <= (r_qacc != '0) ? S_QSQRT_W : S_VCHK;
                end
                S_QSQRT_W: begin
                    if (sqrt_done) begin
                        r_root  <= sqrt_root;
                        r_k     <= '0;
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: r_state <= S_QDIV_W;
                S_QDIV_W: begin
                    if (div_done) begin
                        r_rot[r_k] <= q_k[15] ? 16'(-rot_mag) : rot_mag;
                        r_k        <= r_k + 2'd1;
                        r_state    <= (r_k == 2'd3) ? S_VCHK : S_QDIV;
                    end
                end
                S_VCHK: begin
                    r_k  <= '0;
                    r_av <= '0;
                    r_sh <= '0;
                    if (r_hp && r_item.gap_ms != '0 && r_item.gap_ms < r_max_gap) begin
                        r_state <= S_VDIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_VDIV: r_state <= S_VDIV_W;
                S_VDIV_W: begin
                    if (div_done) begin
                        r_v[r_k] <= d_k[32] ? 44'(-div_quot[42:0]) : {1'b0, div_quot[42:0]};
                        if (div_quot[42:0] > r_av) begin
                            r_av <= div_quot[42:0];
                        end
                        r_k     <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                        r_state <= (r_k == 2'd2) ? S_VSHIFT : S_VDIV;
                    end
                end
                S_VSHIFT: begin
                    // smallest shift that brings every magnitude below 2^31
                    if ((r_av >> r_sh) >= 43'h0_8000_0000) begin
                        r_sh <= r_sh + 4'd1;
                    end else begin
                        r_vacc  <= '0;
                        r_state <= S_VSQ;
                    end
                end
                S_VSQ: begin
                    r_prod  <= 62'(u_k) * 62'(u_k);
                    r_state <= S_VACC;
                end
                S_VACC: begin
                    r_vacc  <= r_vacc + 64'(r_prod);
                    r_k     <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    r_state <= (r_k == 2'd2) ? S_VSQRT : S_VSQ;
                end
                S_VSQRT: r_state <= S_VSQRT_W;
                S_VSQRT_W: begin
                    if (sqrt_done) begin
                        r_m     <= sqrt_root;
                        r_state <= S_VCMP;
                    end
                end
                S_VCMP: begin
                    if (m_shifted > 64'(r_max_speed)) begin
                        r_k     <= '0;
                        r_state <= S_VMUL;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_v[i] > 44'sh7FFF_FFFF) begin
                                r_v[i] <= 44'sh7FFF_FFFF;
                            end else if (r_v[i] < -44'sh8000_0000) begin
                                r_v[i] <= -44'sh8000_0000;
                            end
                        end
                        r_state <= S_FIN;
                    end
                end
                S_VMUL: begin
                    r_prod  <= 62'(u_k) * 62'(r_max_speed);
                    r_state <= S_VSDIV;
                end
                S_VSDIV: r_state <= S_VSDIV_W;
                S_VSDIV_W: begin
                    if (div_done) begin
                        r_v[r_k] <= r_v[r_k][43] ? 44'(-div_quot[31:0])
                                                 : {12'd0, div_quot[31:0]};
                        r_k      <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                        r_state  <= (r_k == 2'd2) ? S_FIN : S_VMUL;
                    end
                end
                S_FIN: begin
                    r_hasprev[id_a] <= 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out   <= out_next;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------- checks
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("report accepted but sequencer stayed idle");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.accepted) |->
            (o_out_data.out_x == '0 && o_out_data.out_y == '0 && o_out_data.out_z == '0
             && o_out_data.vel_x == '0 && o_out_data.vel_y == '0
             && o_out_data.vel_z == '0 && o_out_data.rot_w == '0
             && o_out_data.tracking_ok == 1'b0))
        else $error("rejected beat carries non-zero fields");

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.rot_w <= 16'sd16384 && o_out_data.rot_w >= -16'sd16384
                         && o_out_data.rot_x <= 16'sd16384 && o_out_data.rot_x >= -16'sd16384))
        else $error("normalised quaternion out of range");

    a_fin_writes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> r_hasprev[id_a])
        else $error("history write did not mark tracker valid");

endmodule

@@ sv/tpc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tpc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_div
// Unsigned restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpc_div
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [31:0] r_rem;
    logic [63:0] r_quot;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_quot[63]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
                r_quot <= {r_quot[62:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ sv/tpc_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tpc_sqrt
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= i_rad;
            end else if (r_busy) begin
                r_rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
                r_root <= {r_root[30:0], ge};
                r_rad  <= {r_rad[61:0], 2'b00};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ tb/tracker_pose_conditioner_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pose_conditioner_check
// Watches the report, result and register channels of the pose conditioner.
// It keeps its own copy of the registers and per-tracker history, works out
// each conditioned pose as a report beat is taken, and compares every result
// beat field by field with the oldest pose still owed.
// ----------------------------------------------------------------------------
module tracker_pose_conditioner_check
    import tpc_pkg::*;
#(
    parameter int TRACKERS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic [9:0]         enable_mask;
    logic [16:0]        ok_conf;
    logic signed [31:0] hip_min, hip_max, foot_min, foot_max;
    logic [30:0]        speed_limit;
    logic [15:0]        gap_limit;

    logic   seen [TRACKERS];
    longint last_raw [TRACKERS][3];
    longint last_out [TRACKERS][3];

    t_out_item expected_poses[$];
    int        mismatches = 0;

    assign o_errors  = mismatches;
    assign o_pending = expected_poses.size();

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag_of(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // (39 new + prev) / 40, halves rounded up
    function automatic longint smooth(longint nw, longint pv);
        longint a, q;
        a = 39 * nw + pv + 20;
        q = a / 40;
        if (a % 40 != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic t_out_item condition_pose(t_in_item it);
        t_out_item       res;
        int              id, i;
        longint          raw[3], o[3], v[3], q[4], lo, hi;
        longint unsigned s, r, num, mag, av, u[3], sum, m;
        int              sh;
        res = '0;
        id = it.tracker_id;
        if (id >= TRACKERS || it.confidence > CONF_ONE) return res;
        if (!enable_mask[id]) return res;
        raw[0] = it.pos_x; raw[1] = it.pos_y; raw[2] = it.pos_z;
        q[0] = it.quat_w; q[1] = it.quat_x; q[2] = it.quat_y; q[3] = it.quat_z;
        for (i = 0; i < 3; i++)
            o[i] = seen[id] ? smooth(raw[i], last_raw[id][i]) : raw[i];
        if (id <= 2) begin
            lo = (id == 0) ? longint'(hip_min) : longint'(foot_min);
            hi = (id == 0) ? longint'(hip_max) : longint'(foot_max);
            if (o[1] < lo) o[1] = lo;
            if (o[1] > hi) o[1] = hi;   // max wins over min
        end
        s = 0;
        for (i = 0; i < 4; i++) s += longint'(q[i] * q[i]);
        if (s != 0) begin
            r = root_floor(s << 28);
            for (i = 0; i < 4; i++) begin
                num = mag_of(q[i]) << 28;
                mag = (num + r / 2) / r;
                if (mag > 16384) mag = 16384;
                q[i] = q[i] < 0 ? -longint'(mag) : longint'(mag);
            end
        end
        for (i = 0; i < 3; i++) v[i] = 0;
        if (seen[id] && it.gap_ms != 0 && it.gap_ms < gap_limit) begin
            av = 0;
            for (i = 0; i < 3; i++) begin
                v[i] = (o[i] - last_out[id][i]) * 1000 / longint'(it.gap_ms);
                if (mag_of(v[i]) > av) av = mag_of(v[i]);
            end
            sh = 0;
            while ((av >> sh) >= 64'h8000_0000) sh++;
            sum = 0;
            for (i = 0; i < 3; i++) begin
                u[i] = mag_of(v[i]) >> sh;
                sum += u[i] * u[i];
            end
            m = root_floor(sum);
            for (i = 0; i < 3; i++) begin
                if ((m << sh) > longint'(speed_limit)) begin
                    mag = u[i] * longint'(speed_limit) / m;
                    v[i] = v[i] < 0 ? -longint'(mag) : longint'(mag);
                end else if (v[i] > 64'sd2147483647) begin
                    v[i] = 64'sd2147483647;
                end else if (v[i] < -64'sd2147483648) begin
                    v[i] = -64'sd2147483648;
                end
            end
        end
        for (i = 0; i < 3; i++) begin
            last_raw[id][i] = raw[i];
            last_out[id][i] = o[i];
        end
        seen[id] = 1'b1;
        res.accepted    = 1'b1;
        res.out_x       = 32'(o[0]);
        res.out_y       = 32'(o[1]);
        res.out_z       = 32'(o[2]);
        res.rot_w       = 16'(q[0]);
        res.rot_x       = 16'(q[1]);
        res.rot_y       = 16'(q[2]);
        res.rot_z       = 16'(q[3]);
        res.vel_x       = 32'(v[0]);
        res.vel_y       = 32'(v[1]);
        res.vel_z       = 32'(v[2]);
        res.tracking_ok = it.confidence > ok_conf;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e, g;
        string     bad;
        if (!i_rst_n) begin
            enable_mask <= RST_ENABLE_MASK;
            ok_conf     <= RST_OK_CONF;
            hip_min     <= RST_HIP_MIN;
            hip_max     <= RST_HIP_MAX;
            foot_min    <= RST_FOOT_MIN;
            foot_max    <= RST_FOOT_MAX;
            speed_limit <= RST_MAX_SPEED;
            gap_limit   <= RST_MAX_GAP;
            for (int t = 0; t < TRACKERS; t++) seen[t] = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                g = i_out_data;
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing owed: %h", $time, g);
                end else begin
                    e = expected_poses.pop_front();
                    bad = "";
                    if (g.accepted !== e.accepted)       bad = {bad, " accepted"};
                    if (g.out_x !== e.out_x)             bad = {bad, " out_x"};
                    if (g.out_y !== e.out_y)             bad = {bad, " out_y"};
                    if (g.out_z !== e.out_z)             bad = {bad, " out_z"};
                    if (g.rot_w !== e.rot_w)             bad = {bad, " rot_w"};
                    if (g.rot_x !== e.rot_x)             bad = {bad, " rot_x"};
                    if (g.rot_y !== e.rot_y)             bad = {bad, " rot_y"};
                    if (g.rot_z !== e.rot_z)             bad = {bad, " rot_z"};
                    if (g.vel_x !== e.vel_x)             bad = {bad, " vel_x"};
                    if (g.vel_y !== e.vel_y)             bad = {bad, " vel_y"};
                    if (g.vel_z !== e.vel_z)             bad = {bad, " vel_z"};
                    if (g.tracking_ok !== e.tracking_ok) bad = {bad, " tracking_ok"};
                    if (bad != "") begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch in%s: expected %h got %h",
                                     $time, bad, e, g);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_poses.insert(expected_poses.size(), condition_pose(i_in_data));
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ENABLE_MASK: enable_mask <= i_cfg_data[9:0];
                    CFG_OK_CONF:     ok_conf     <= i_cfg_data[16:0];
                    CFG_HIP_MIN:     hip_min     <= i_cfg_data;
                    CFG_HIP_MAX:     hip_max     <= i_cfg_data;
                    CFG_FOOT_MIN:    foot_min    <= i_cfg_data;
                    CFG_FOOT_MAX:    foot_max    <= i_cfg_data;
                    CFG_MAX_SPEED:   speed_limit <= i_cfg_data[30:0];
                    CFG_MAX_GAP:     gap_limit   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/tracker_pose_conditioner_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pose_conditioner_test
// Drives pose reports and register writes into the conditioner over several
// register settings: a directed set of edge cases, then random tracker
// sequences with occasional malformed reports, under random idling on both
// sides. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tracker_pose_conditioner_test;
    import tpc_pkg::*;

    localparam int TRACKERS = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    int   errors, pending;
    logic quiet = 1'b0;
    int   last_pos [16][3];

    always #4 i_clk = ~i_clk;

    tracker_pose_conditioner #(.TRACKERS(TRACKERS)) uut (.*);

    tracker_pose_conditioner_check #(.TRACKERS(TRACKERS)) u_check (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 14);
    end

    initial begin
        #160_000_000;
        $display("tracker_pose_conditioner_test NOT OK");
        $finish;
    end

    function automatic t_in_item report(int id, int x, int y, int z, int w, int qx,
                                        int qy, int qz, int conf, int gap);
        t_in_item it;
        it.tracker_id = 4'(id);
        it.pos_x = x; it.pos_y = y; it.pos_z = z;
        it.quat_w = 16'(w); it.quat_x = 16'(qx);
        it.quat_y = 16'(qy); it.quat_z = 16'(qz);
        it.confidence = 17'(conf);
        it.gap_ms = 16'(gap);
        return it;
    endfunction

    task automatic send(t_in_item it);
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (it.tracker_id < TRACKERS) begin
            last_pos[it.tracker_id][0] = it.pos_x;
            last_pos[it.tracker_id][1] = it.pos_y;
            last_pos[it.tracker_id][2] = it.pos_z;
        end
        if (!quiet && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    // hold the report channel idle until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int coord(int id, int k);
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return last_pos[id][k] + $urandom_range(0, 4000) - 2000;
        if (sel < 90) return $urandom_range(0, 262143) - 131072;
        return $urandom;
    endfunction

    function automatic int quat_part();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return $urandom_range(0, 8192) - 4096;
        if (sel < 95) return $urandom_range(0, 65535);
        return 0;
    endfunction

    function automatic t_in_item random_report(int gap_limit);
        int id, conf, gap, sel;
        id = ($urandom_range(99) < 90) ? $urandom_range(0, TRACKERS - 1)
                                       : $urandom_range(TRACKERS, 15);
        sel = $urandom_range(99);
        conf = (sel < 88) ? $urandom_range(0, 65536)
             : (sel < 92) ? 65536 : $urandom_range(65537, 131071);
        sel = $urandom_range(99);
        gap = (sel < 75) ? $urandom_range(1, (gap_limit > 1) ? gap_limit - 1 : 1)
            : (sel < 82) ? 0 : $urandom_range(0, 65535);
        if ($urandom_range(99) < 5)
            return report(id, coord(id, 0), coord(id, 1), coord(id, 2),
                          0, 0, 0, 0, conf, gap);
        return report(id, coord(id, 0), coord(id, 1), coord(id, 2), quat_part(),
                      quat_part(), quat_part(), quat_part(), conf, gap);
    endfunction

    initial begin
        int gap_limit;
        for (int t = 0; t < 16; t++)
            for (int k = 0; k < 3; k++) last_pos[t][k] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every tracker disabled out of reset
        send(report(0, 65536, 65536, 0, 4096, 0, 0, 0, 65536, 10));
        send(report(5, 1, 2, 3, 0, 4096, 0, 0, 100, 10));
        drain();
        set_reg(CFG_ENABLE_MASK, 32'h3FF);

        send(report(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    -32768, -32768, -32768, -32768, 65536, 0));
        send(report(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32767, 32767, 32767, 32767, 0, 1));
        send(report(0, 0, 65536, 0, 0, 0, 0, 0, 65537, 5));
        send(report(0, 100000, 70000, -5000, 4096, 0, 0, 0, 39322, 99));
        send(report(0, 100100, 70100, -5100, 0, 0, 0, 1, 39323, 100));
        send(report(0, 100200, 70200, -5200, 1, 0, 0, 0, 131071, 20));
        send(report(1, 0, -65536, 0, 2896, 2896, 0, 0, 50000, 10));
        send(report(1, 0, 65536, 0, -2896, 0, 2896, 0, 50000, 10));
        send(report(2, 5, 10000, 5, 0, 0, 0, -4096, 65536, 1));
        send(report(2, -5, 10001, -5, 0, 0, -4096, 0, 65536, 65535));
        send(report(3, 32'h7FFF_FFFF, 0, 0, 4096, 4096, 4096, 4096, 1000, 1));
        send(report(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    4096, 0, 0, 0, 1000, 1));
        send(report(10, 1, 1, 1, 4096, 0, 0, 0, 100, 10));
        send(report(15, 1, 1, 1, 4096, 0, 0, 0, 100, 10));
        send(report(9, 123456, 654321, -999, 4096, 0, 0, 0, 65536, 50));
        send(report(9, 123000, 654000, -900, 4096, 0, 0, 0, 65536, 50));

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin
                    set_reg(CFG_OK_CONF, 32'd39322);
                    set_reg(CFG_MAX_GAP, 32'd100);
                end
                1: begin
                    set_reg(CFG_ENABLE_MASK, 32'h2B5);
                    set_reg(CFG_OK_CONF, 32'd0);
                    set_reg(CFG_HIP_MIN, 32'h7FFF_FFFF);
                    set_reg(CFG_HIP_MAX, 32'h8000_0000);
                    set_reg(CFG_FOOT_MIN, 32'h8000_0000);
                    set_reg(CFG_FOOT_MAX, 32'h7FFF_FFFF);
                    set_reg(CFG_MAX_SPEED, 32'd0);
                    set_reg(CFG_MAX_GAP, 32'd1);
                end
                2: begin
                    set_reg(CFG_ENABLE_MASK, 32'h3FF);
                    set_reg(CFG_OK_CONF, 32'd65536);
                    set_reg(CFG_MAX_SPEED, 32'h7FFF_FFFF);
                    set_reg(CFG_MAX_GAP, 32'd65535);
                end
                3: begin
                    set_reg(CFG_ENABLE_MASK, $urandom | 32'h1);
                    set_reg(CFG_OK_CONF, $urandom_range(0, 65536));
                    set_reg(CFG_HIP_MIN, $urandom_range(0, 262143) - 131072);
                    set_reg(CFG_HIP_MAX, $urandom_range(0, 262143) - 131072);
                    set_reg(CFG_FOOT_MIN, $urandom);
                    set_reg(CFG_FOOT_MAX, $urandom);
                    set_reg(CFG_MAX_SPEED, $urandom_range(0, 2000000));
                    set_reg(CFG_MAX_GAP, $urandom_range(1, 65535));
                end
                default: begin
                    set_reg(CFG_ENABLE_MASK, 32'h3FF);
                    set_reg(CFG_OK_CONF, 32'd39322);
                    set_reg(CFG_HIP_MIN, 32'd52429);
                    set_reg(CFG_HIP_MAX, 32'd78643);
                    set_reg(CFG_FOOT_MIN, 32'd0);
                    set_reg(CFG_FOOT_MAX, 32'd19661);
                    set_reg(CFG_MAX_SPEED, 32'd327680);
                    set_reg(CFG_MAX_GAP, 32'd200);
                end
            endcase
            gap_limit = (ph == 1) ? 200 : (ph == 2) ? 300 : (ph == 4) ? 200 : 100;
            quiet <= (ph == 2);
            for (int n = 0; n < 385; n++) begin
                send(random_report(gap_limit));
                if (ph == 4 && n == 190) drain();
            end
        end

        i_in_valid <= 1'b0;
        quiet <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tracker_pose_conditioner_test OK");
        end else begin
            $display("tracker_pose_conditioner_test NOT OK");
        end
        $finish;
    end

endmodule
